>>> design/svd_pkg.sv
// Shared types, constants and trellis helper functions of the soft Viterbi decoder.
`default_nettype none

package svd_pkg;

   localparam int CONSTRAINT_LEN = 7;
   localparam int WINDOW_DEPTH   = 35;
   localparam int METRIC_W       = 16;

   localparam int MEM_LEN     = CONSTRAINT_LEN - 1;
   localparam int STATE_W     = MEM_LEN;
   localparam int NSTATES     = 1 << MEM_LEN;
   localparam int NCOLS       = WINDOW_DEPTH + 1;
   localparam int COL_W       = $clog2(NCOLS);
   localparam int SURV_DEPTH  = NCOLS * NSTATES;
   localparam int ROW_W       = 2 * METRIC_W;
   localparam int MRAM_DEPTH  = NSTATES;
   localparam int EXTRA_BITS  = WINDOW_DEPTH - MEM_LEN - 1;
   localparam int TP_W        = NCOLS;
   localparam int EMIT_W      = $clog2(EXTRA_BITS + 2);

   localparam logic [METRIC_W-1:0] UNREACHED  = {METRIC_W{1'b1}};
   localparam logic [METRIC_W-1:0] METRIC_MAX = UNREACHED - 1'b1;

   localparam int POLY_W  = 7;
   localparam int QSTEP_W = 6;
   localparam int Q_W     = 3;
   localparam int BM_W    = 4;

   // Configuration register indexes.
   localparam logic [1:0] CSR_GEN_POLY_A = 2'd0;
   localparam logic [1:0] CSR_GEN_POLY_B = 2'd1;
   localparam logic [1:0] CSR_QUANT_STEP = 2'd2;

   typedef struct packed {
      logic signed [7:0] sym_a;
      logic signed [7:0] sym_b;
      logic              tail;
      logic              block_end;
   } svd_req_type;

   typedef struct packed {
      logic decoded_bit;
      logic final_bit;
   } svd_rsp_type;

   // Control handed from the sequencer to the add-compare-select unit.
   typedef struct packed {
      logic                 fresh;
      logic                 tail;
      logic [STATE_W-1:0]   stride_mask;
      logic [STATE_W-1:0]   limit_mask;
      logic [METRIC_W-1:0]  lo;
      logic [POLY_W-1:0]    poly_a;
      logic [POLY_W-1:0]    poly_b;
      logic [Q_W-1:0]       qa;
      logic [Q_W-1:0]       qb;
   } svd_acs_ctl_type;

   // Three-bit soft quantizer: strongly negative gives 7, strongly positive 0.
   function automatic logic [Q_W-1:0] quantize(input logic signed [7:0] x,
                                                input logic [QSTEP_W-1:0] d);
      logic signed [9:0] xs;
      logic signed [9:0] d1;
      logic signed [9:0] d2;
      logic signed [9:0] d3;
      logic [Q_W-1:0]    q;
      xs = {{2{x[7]}}, x};
      d1 = $signed({4'b0000, d});
      d2 = d1 <<< 1;
      d3 = d1 + d2;
      priority if (xs < -d3) q = 3'd7;
      else if (xs < -d2)     q = 3'd6;
      else if (xs < -d1)     q = 3'd5;
      else if (xs < 10'sd0)  q = 3'd4;
      else if (xs < d1)      q = 3'd3;
      else if (xs < d2)      q = 3'd2;
      else if (xs < d3)      q = 3'd1;
      else                   q = 3'd0;
      return q;
   endfunction

   // Encoder output bit for a source state and input bit.
   function automatic logic code_bit(input logic [POLY_W-1:0] taps,
                                     input logic [STATE_W-1:0] st,
                                     input logic b);
      logic [POLY_W-1:0] sr;
      sr = '0;
      sr[0] = b;
      for (int i = 1; i <= MEM_LEN; i++) begin
         sr[i] = st[MEM_LEN-i];
      end
      return ^(sr & taps);
   endfunction

   function automatic logic [BM_W-1:0] edge_cost(input svd_acs_ctl_type c,
                                                 input logic [STATE_W-1:0] st,
                                                 input logic b);
      logic [Q_W-1:0] da;
      logic [Q_W-1:0] db;
      da = code_bit(c.poly_a, st, b) ? (3'd7 - c.qa) : c.qa;
      db = code_bit(c.poly_b, st, b) ? (3'd7 - c.qb) : c.qb;
      return {1'b0, da} + {1'b0, db};
   endfunction

endpackage

`default_nettype wire

>>> design/svd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module svd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

>>> design/svd_acs.sv
// Pipelined add-compare-select unit, one destination state per cycle.
`default_nettype none

module svd_acs
   import svd_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire svd_acs_ctl_type     ctl,
   input  wire logic                in_valid,
   input  wire logic [STATE_W-1:0]  in_nx,
   input  wire logic [ROW_W-1:0]    in_row,
   output logic                     out_valid,
   output logic [STATE_W-1:0]       out_nx,
   output logic [METRIC_W-1:0]      out_metric,
   output logic [STATE_W-1:0]       out_surv
);

   logic                s2_valid_ff, s2_valid_in;
   logic [STATE_W-1:0]  s2_nx_ff, s2_nx_in;
   logic [METRIC_W-1:0] s2_pm0_ff, s2_pm0_in, s2_pm1_ff, s2_pm1_in;
   logic                s2_v0_ff, s2_v0_in, s2_v1_ff, s2_v1_in;

   logic                s3_valid_ff, s3_valid_in;
   logic [STATE_W-1:0]  s3_nx_ff, s3_nx_in;
   logic [METRIC_W-1:0] s3_metric_ff, s3_metric_in;
   logic [STATE_W-1:0]  s3_surv_ff, s3_surv_in;

   logic [STATE_W-1:0]  j0, j1, k0, k1;
   logic [METRIC_W-1:0] raw0, raw1;
   logic                ok0, ok1;
   logic [METRIC_W:0]   sum0, sum1;
   logic [METRIC_W-1:0] cand0, cand1;

   // Stage one: both predecessors share one metric row; renormalize or zero them.
   always_comb begin
      j0   = {in_nx[STATE_W-2:0], 1'b0};
      j1   = {in_nx[STATE_W-2:0], 1'b1};
      raw0 = in_row[METRIC_W-1:0];
      raw1 = in_row[ROW_W-1:METRIC_W];
      if (ctl.tail) begin
         ok0 = ((j0 & ~ctl.limit_mask) == '0) && !in_nx[STATE_W-1];
         ok1 = ((j1 & ~ctl.limit_mask) == '0) && !in_nx[STATE_W-1];
      end else begin
         ok0 = (j0 & ctl.stride_mask) == '0;
         ok1 = (j1 & ctl.stride_mask) == '0;
      end
      s2_valid_in = in_valid;
      s2_nx_in    = in_nx;
      if (ctl.fresh) begin
         s2_pm0_in = '0;
         s2_pm1_in = '0;
         s2_v0_in  = ok0;
         s2_v1_in  = ok1;
      end else begin
         s2_pm0_in = (raw0 == UNREACHED) ? UNREACHED : raw0 - ctl.lo;
         s2_pm1_in = (raw1 == UNREACHED) ? UNREACHED : raw1 - ctl.lo;
         s2_v0_in  = ok0 && (raw0 != UNREACHED);
         s2_v1_in  = ok1 && (raw1 != UNREACHED);
      end
   end

   // Stage two: add branch metrics, clamp, and select; the even source wins ties.
   always_comb begin
      k0    = {s2_nx_ff[STATE_W-2:0], 1'b0};
      k1    = {s2_nx_ff[STATE_W-2:0], 1'b1};
      sum0  = {1'b0, s2_pm0_ff} + {{(METRIC_W+1-BM_W){1'b0}},
                                   edge_cost(ctl, k0, s2_nx_ff[STATE_W-1])};
      sum1  = {1'b0, s2_pm1_ff} + {{(METRIC_W+1-BM_W){1'b0}},
                                   edge_cost(ctl, k1, s2_nx_ff[STATE_W-1])};
      cand0 = (sum0 > {1'b0, METRIC_MAX}) ? METRIC_MAX : sum0[METRIC_W-1:0];
      cand1 = (sum1 > {1'b0, METRIC_MAX}) ? METRIC_MAX : sum1[METRIC_W-1:0];
      s3_valid_in = s2_valid_ff;
      s3_nx_in    = s2_nx_ff;
      if (s2_v0_ff && (!s2_v1_ff || (cand0 <= cand1))) begin
         s3_metric_in = cand0;
         s3_surv_in   = k0;
      end else if (s2_v1_ff) begin
         s3_metric_in = cand1;
         s3_surv_in   = k1;
      end else begin
         s3_metric_in = UNREACHED;
         s3_surv_in   = k0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
      s2_nx_ff     <= s2_nx_in;
      s2_pm0_ff    <= s2_pm0_in;
      s2_pm1_ff    <= s2_pm1_in;
      s2_v0_ff     <= s2_v0_in;
      s2_v1_ff     <= s2_v1_in;
      s3_nx_ff     <= s3_nx_in;
      s3_metric_ff <= s3_metric_in;
      s3_surv_ff   <= s3_surv_in;
   end

   assign out_valid  = s3_valid_ff;
   assign out_nx     = s3_nx_ff;
   assign out_metric = s3_metric_ff;
   assign out_surv   = s3_surv_ff;

endmodule

`default_nettype wire

>>> design/soft_viterbi_decoder_rate_half_top.sv
// Top level of the rate one-half soft-decision Viterbi decoder with its sequencer.
// An item passes from its transfer through a quantize state, the 64-state ACS sweep through its
// pipeline and the sweep-end bookkeeping, then, once the window is full, a 35-step traceback (each
// step an address state and a data state for the registered survivor memory read), and the emit
// state; emitted bits then leave one per cycle as the result side takes them. One item is
// processed at a time.
`default_nettype none

module soft_viterbi_decoder_rate_half_top
   import svd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire svd_req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output svd_rsp_type      rsp_data,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_addr,
   input  wire logic [6:0]  csr_wdata
);

   // Sequencer state codes.
   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_QUANT   = 3'd1;
   localparam logic [2:0] ST_ACS     = 3'd2;
   localparam logic [2:0] ST_ACS_END = 3'd3;
   localparam logic [2:0] ST_TB_ADDR = 3'd4;
   localparam logic [2:0] ST_TB_DATA = 3'd5;
   localparam logic [2:0] ST_EMIT    = 3'd6;

   localparam logic [COL_W-1:0]   LAST_COL  = COL_W'(NCOLS - 1);
   localparam logic [5:0]         TB_START  = 6'(WINDOW_DEPTH - 1);
   localparam logic [COL_W-1:0]   TB_STEPS  = COL_W'(WINDOW_DEPTH);
   localparam logic [2:0]         TC_LIMIT  = 3'(MEM_LEN - 1);
   localparam int                 CNT_W     = STATE_W + 1;

   logic [2:0]           state_ff, state_in;
   svd_req_type          req_ff, req_in;
   logic [POLY_W-1:0]    poly_a_ff, poly_a_in, poly_b_ff, poly_b_in;
   logic [QSTEP_W-1:0]   qstep_ff, qstep_in;
   logic [Q_W-1:0]       qa_ff, qa_in, qb_ff, qb_in;
   logic [5:0]           step_ff, step_in;
   logic [2:0]           tailc_ff, tailc_in;
   logic [COL_W-1:0]     col_ff, col_in, colnew_ff, colnew_in;
   logic                 fresh_ff, fresh_in;
   logic [METRIC_W-1:0]  lo_ff, lo_in, lo_run_ff, lo_run_in;
   logic [METRIC_W-1:0]  best_m_ff, best_m_in, half_ff, half_in;
   logic [STATE_W-1:0]   best_s_ff, best_s_in;
   logic                 bank_ff, bank_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 s1_valid_ff, s1_valid_in;
   logic [STATE_W-1:0]   s1_nx_ff, s1_nx_in;
   logic [STATE_W-1:0]   tb_state_ff, tb_state_in;
   logic [COL_W-1:0]     tb_col_ff, tb_col_in, tb_cnt_ff, tb_cnt_in;
   logic [TP_W-1:0]      tp_ff, tp_in;
   logic [EMIT_W-1:0]    emit_ff, emit_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   svd_rsp_type          rsp_data_ff, rsp_data_in;

   svd_acs_ctl_type      acs_ctl;
   logic                 acs_valid;
   logic [STATE_W-1:0]   acs_nx, acs_surv;
   logic [METRIC_W-1:0]  acs_metric;
   logic [ROW_W-1:0]     mrow_rd;
   logic                 mram_we;
   logic [STATE_W-1:0]   mram_wr_addr, mram_rd_addr;
   logic [STATE_W-1:0]   surv_rd;
   logic                 issue;
   logic [2:0]           tc;
   logic                 considered, better;
   logic [STATE_W-2:0]   pair_new, pair_best;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Tail items shrink the searched state range; the shift saturates after the flush.
   assign tc    = (tailc_ff < TC_LIMIT) ? tailc_ff : TC_LIMIT;
   assign issue = (state_ff == ST_ACS) && !cnt_ff[CNT_W-1];

   always_comb begin
      acs_ctl.fresh       = fresh_ff;
      acs_ctl.tail        = req_ff.tail;
      acs_ctl.stride_mask = {STATE_W{1'b1}} >> step_ff;
      acs_ctl.limit_mask  = {STATE_W{1'b1}} >> tc;
      acs_ctl.lo          = lo_ff;
      acs_ctl.poly_a      = poly_a_ff;
      acs_ctl.poly_b      = poly_b_ff;
      acs_ctl.qa          = qa_ff;
      acs_ctl.qb          = qb_ff;
   end

   // Path metrics live in two banks of packed even/odd rows; one bank is read while the
   // other is written, and the banks swap at the end of each sweep.
   assign mram_rd_addr = {bank_ff, cnt_ff[STATE_W-2:0]};
   assign mram_wr_addr = {~bank_ff, acs_nx[STATE_W-1:1]};
   assign mram_we      = acs_valid && acs_nx[0];

   svd_ram #(.WIDTH(ROW_W), .DEPTH(MRAM_DEPTH)) u_metric_ram (
      .clock   (clock),
      .wr_en   (mram_we),
      .wr_addr (mram_wr_addr),
      .wr_data ({acs_metric, half_ff}),
      .rd_addr (mram_rd_addr),
      .rd_data (mrow_rd)
   );

   // Survivor memory: one row of predecessors per trellis column.
   svd_ram #(.WIDTH(STATE_W), .DEPTH(SURV_DEPTH)) u_surv_ram (
      .clock   (clock),
      .wr_en   (acs_valid),
      .wr_addr ({colnew_ff, acs_nx}),
      .wr_data (acs_surv),
      .rd_addr ({tb_col_ff, tb_state_ff}),
      .rd_data (surv_rd)
   );

   svd_acs u_acs (
      .clock      (clock),
      .reset      (reset),
      .ctl        (acs_ctl),
      .in_valid   (s1_valid_ff),
      .in_nx      (s1_nx_ff),
      .in_row     (mrow_rd),
      .out_valid  (acs_valid),
      .out_nx     (acs_nx),
      .out_metric (acs_metric),
      .out_surv   (acs_surv)
   );

   // Best-state search rides along the sweep. Ordinary items rank mirror pairs from the
   // outside in with the upper state winning a tie inside a pair; tail items take the
   // lowest numbered minimum below the tail limit.
   always_comb begin
      pair_new  = acs_nx[STATE_W-1] ? ~acs_nx[STATE_W-2:0] : acs_nx[STATE_W-2:0];
      pair_best = best_s_ff[STATE_W-1] ? ~best_s_ff[STATE_W-2:0] : best_s_ff[STATE_W-2:0];
      if (req_ff.tail) begin
         considered = (acs_nx & ~acs_ctl.limit_mask) == '0;
         better     = (acs_nx == '0) || (acs_metric < best_m_ff);
      end else begin
         considered = 1'b1;
         better     = (acs_nx == '0) || (acs_metric < best_m_ff) ||
                      ((acs_metric == best_m_ff) &&
                       ((pair_new < pair_best) ||
                        ((pair_new == pair_best) && (acs_nx > best_s_ff))));
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      poly_a_in    = poly_a_ff;
      poly_b_in    = poly_b_ff;
      qstep_in     = qstep_ff;
      qa_in        = qa_ff;
      qb_in        = qb_ff;
      step_in      = step_ff;
      tailc_in     = tailc_ff;
      col_in       = col_ff;
      colnew_in    = colnew_ff;
      fresh_in     = fresh_ff;
      lo_in        = lo_ff;
      lo_run_in    = lo_run_ff;
      best_m_in    = best_m_ff;
      best_s_in    = best_s_ff;
      half_in      = half_ff;
      bank_in      = bank_ff;
      cnt_in       = cnt_ff;
      s1_valid_in  = issue;
      s1_nx_in     = cnt_ff[STATE_W-1:0];
      tb_state_in  = tb_state_ff;
      tb_col_in    = tb_col_ff;
      tb_cnt_in    = tb_cnt_ff;
      tp_in        = tp_ff;
      emit_in      = emit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      // Configuration writes are expected only while idle; an index past the list is dropped.
      if (csr_we) begin
         unique case (csr_addr)
            CSR_GEN_POLY_A: poly_a_in = csr_wdata[POLY_W-1:0];
            CSR_GEN_POLY_B: poly_b_in = csr_wdata[POLY_W-1:0];
            CSR_QUANT_STEP: qstep_in  = csr_wdata[QSTEP_W-1:0];
            default: ;
         endcase
      end

      if (acs_valid) begin
         if (!acs_nx[0]) begin
            half_in = acs_metric;
         end
         if (acs_metric < lo_run_ff) begin
            lo_run_in = acs_metric;
         end
         if (considered && better) begin
            best_m_in = acs_metric;
            best_s_in = acs_nx;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = ST_QUANT;
            end
         end
         ST_QUANT: begin
            qa_in     = quantize(req_ff.sym_a, qstep_ff);
            qb_in     = quantize(req_ff.sym_b, qstep_ff);
            colnew_in = (col_ff == LAST_COL) ? '0 : col_ff + 1'b1;
            cnt_in    = '0;
            lo_run_in = UNREACHED;
            state_in  = ST_ACS;
         end
         ST_ACS: begin
            if (issue) begin
               cnt_in = cnt_ff + 1'b1;
            end
            if (acs_valid && (acs_nx == {STATE_W{1'b1}})) begin
               state_in = ST_ACS_END;
            end
         end
         ST_ACS_END: begin
            lo_in    = lo_run_ff;
            bank_in  = ~bank_ff;
            fresh_in = 1'b0;
            col_in   = colnew_ff;
            if (step_ff != 6'h3F) begin
               step_in = step_ff + 1'b1;
            end
            if (req_ff.tail && (tailc_ff != 3'h7)) begin
               tailc_in = tailc_ff + 1'b1;
            end
            emit_in = (req_ff.block_end ? EMIT_W'(EXTRA_BITS) : '0) +
                      EMIT_W'(step_ff >= TB_START);
            if (step_ff >= TB_START) begin
               tp_in       = {tp_ff[TP_W-2:0], best_s_ff[STATE_W-1]};
               tb_state_in = best_s_ff;
               tb_col_in   = colnew_ff;
               tb_cnt_in   = TB_STEPS;
               state_in    = ST_TB_ADDR;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_TB_ADDR: begin
            state_in = ST_TB_DATA;
         end
         ST_TB_DATA: begin
            tb_state_in = surv_rd;
            tp_in       = {tp_ff[TP_W-2:0], surv_rd[STATE_W-1]};
            tb_col_in   = (tb_col_ff == '0) ? LAST_COL : tb_col_ff - 1'b1;
            tb_cnt_in   = tb_cnt_ff - 1'b1;
            state_in    = (tb_cnt_ff == COL_W'(1)) ? ST_EMIT : ST_TB_ADDR;
         end
         ST_EMIT: begin
            if (emit_ff == '0) begin
               if (req_ff.block_end) begin
                  fresh_in = 1'b1;
                  col_in   = '0;
                  step_in  = '0;
                  tailc_in = '0;
               end
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.decoded_bit = tp_ff[1];
               rsp_data_in.final_bit   = req_ff.block_end && (emit_ff == EMIT_W'(1));
               tp_in                   = tp_ff >> 1;
               emit_in                 = emit_ff - 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         poly_a_ff    <= POLY_W'(79);
         poly_b_ff    <= POLY_W'(109);
         qstep_ff     <= QSTEP_W'(10);
         step_ff      <= '0;
         tailc_ff     <= '0;
         col_ff       <= '0;
         fresh_ff     <= 1'b1;
         bank_ff      <= 1'b0;
         cnt_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         emit_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         poly_a_ff    <= poly_a_in;
         poly_b_ff    <= poly_b_in;
         qstep_ff     <= qstep_in;
         step_ff      <= step_in;
         tailc_ff     <= tailc_in;
         col_ff       <= col_in;
         fresh_ff     <= fresh_in;
         bank_ff      <= bank_in;
         cnt_ff       <= cnt_in;
         s1_valid_ff  <= s1_valid_in;
         emit_ff      <= emit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff      <= req_in;
      qa_ff       <= qa_in;
      qb_ff       <= qb_in;
      colnew_ff   <= colnew_in;
      lo_ff       <= lo_in;
      lo_run_ff   <= lo_run_in;
      best_m_ff   <= best_m_in;
      best_s_ff   <= best_s_in;
      half_ff     <= half_in;
      s1_nx_ff    <= s1_nx_in;
      tb_state_ff <= tb_state_in;
      tb_col_ff   <= tb_col_in;
      tb_cnt_ff   <= tb_cnt_in;
      tp_ff       <= tp_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef ASSERT_OFF
   // For an ordinary item the best state must carry the smallest metric of the sweep.
   a_best_is_min: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACS_END && !req_ff.tail) |-> (best_m_ff == lo_run_ff))
      else $error("best state metric differs from sweep minimum");

   // Survivor entries are written only by the add-compare-select sweep.
   a_surv_write: assert property (@(posedge clock) disable iff (reset)
      acs_valid |-> (state_ff == ST_ACS))
      else $error("survivor write outside the sweep");

   // A traceback read never runs past the last step of the window.
   a_tb_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TB_DATA) |-> (tb_cnt_ff != '0))
      else $error("traceback step count underflow");

   // A result first goes valid only out of the emit state.
   a_no_rsp_new: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid_ff)) |-> ($past(state_ff) == ST_EMIT))
      else $error("result produced outside emission");
`endif

endmodule

`default_nettype wire
